@@ src/ccrc_pkg.sv @@
`timescale 1ns / 1ps

package ccrc_pkg;

	// CRC width codes
	localparam logic [1:0] WSEL_8       = 2'd0;
	localparam logic [1:0] WSEL_16      = 2'd1;
	localparam logic [1:0] WSEL_32      = 2'd2;
	localparam logic [1:0] WSEL_INVALID = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFLECTED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_XOR   = 3'd4;

	localparam logic [31:0] RESET_POLYNOMIAL = 32'hEDB8_8320;
	localparam logic [31:0] RESET_INITIAL    = 32'hFFFF_FFFF;
	localparam logic [31:0] RESET_OUTPUT_XOR = 32'hFFFF_FFFF;

	// Settings the bit-step logic needs
	typedef struct packed {
		logic [1:0]  wsel;
		logic        reflected;
		logic [31:0] poly;
	} ccrc_cfg_t;

	function automatic logic [31:0] width_mask(input logic [1:0] wsel);
		logic [31:0] m;
		unique case (wsel)
			WSEL_8:  m = 32'h0000_00FF;
			WSEL_16: m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

@@ src/configurable_crc_engine.sv @@
`timescale 1ns / 1ps

// Byte-serial CRC engine, 8/16/32-bit, normal or reflected.
// Configuration: write width_select (0), reflected_mode (1), polynomial (2),
// initial_value (3) and output_xor (4) through cfg_wen/cfg_index/cfg_data while
// no item is in flight. Indexes beyond 4 are ignored.
// Input channel: one item per accepted in_valid && !in_stall. start_of_message
// loads the initial value, byte_present folds data_byte in, end_of_message asks
// for a result after this item.
// Output channel: one result (crc_value, status) per item with end_of_message;
// status is 1 and crc_value 0 when the width code is invalid.
// Pipeline: an item is registered at acceptance; once it may leave that register
// it is folded into the CRC register and any result is registered onto out_valid.
// Throughput: one item per cycle while in_stall is low; the eight bit steps of
// a byte are combinational XOR logic between input and CRC/result registers.
// Stall: a result held by out_stall blocks only a following item that also ends
// a message; in_stall then rises until the result is taken.
// Reset: the CRC register clears, configuration returns to CRC-32 (reflected,
// 0xEDB88320, init and output XOR all ones), no item or result is held.
module configurable_crc_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [ccrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         data_byte,
	input  logic                               byte_present,
	input  logic                               start_of_message,
	input  logic                               end_of_message,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [31:0]                        crc_value,
	output logic                               status
);
	import ccrc_pkg::*;

	logic [1:0]  wsel_q;
	logic        refl_q;
	logic [31:0] poly_q;
	logic [31:0] init_q;
	logic [31:0] oxor_q;
	logic [31:0] crc_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        present_s1;
	logic        start_s1;
	logic        end_s1;

	logic        out_valid_q;
	logic [31:0] crc_value_q;
	logic        status_q;

	ccrc_cfg_t   cfg;
	logic [31:0] mask;
	logic        width_ok;
	logic [31:0] seed;
	logic [31:0] folded;
	logic [31:0] crc_next;
	logic        go;
	logic        accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= WSEL_32;
			refl_q <= 1'b1;
			poly_q <= RESET_POLYNOMIAL;
			init_q <= RESET_INITIAL;
			oxor_q <= RESET_OUTPUT_XOR;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_WIDTH_SELECT: wsel_q <= cfg_data[1:0];
				REG_REFLECTED:    refl_q <= cfg_data[0];
				REG_POLYNOMIAL:   poly_q <= cfg_data;
				REG_INITIAL:      init_q <= cfg_data;
				REG_OUTPUT_XOR:   oxor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// an item leaves stage 1 unless it ends a message and the result slot is held
	assign go       = valid_s1 && (!end_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !go);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1    <= data_byte;
			present_s1 <= byte_present;
			start_s1   <= start_of_message;
			end_s1     <= end_of_message;
		end
	end

	assign cfg.wsel      = wsel_q;
	assign cfg.reflected = refl_q;
	assign cfg.poly      = poly_q;

	ccrc_fold u_fold (
		.cfg     (cfg),
		.crc_in  (seed),
		.data_in (byte_s1),
		.crc_out (folded)
	);

	always_comb begin
		mask     = width_mask(wsel_q);
		width_ok = (wsel_q != WSEL_INVALID);
		seed     = start_s1 ? (init_q & mask) : crc_q;
		if (!width_ok) begin
			crc_next = crc_q;
		end else if (present_s1) begin
			crc_next = folded;
		end else begin
			crc_next = seed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 32'd0;
		end else if (go) begin
			crc_q <= crc_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && end_s1) begin
			crc_value_q <= width_ok ? ((crc_next ^ oxor_q) & mask) : 32'd0;
			status_q    <= !width_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;
	assign status    = status_q;

endmodule

@@ src/ccrc_fold.sv @@
`timescale 1ns / 1ps

module ccrc_fold (
	input  ccrc_pkg::ccrc_cfg_t cfg,
	input  logic [31:0]         crc_in,
	input  logic [7:0]          data_in,
	output logic [31:0]         crc_out
);
	import ccrc_pkg::*;

	logic [31:0] mask;
	logic [31:0] poly;
	logic [31:0] top;
	logic [31:0] c;

	always_comb begin
		mask = width_mask(cfg.wsel);
		poly = cfg.poly & mask;
		unique case (cfg.wsel)
			WSEL_8:  top = 32'h0000_0080;
			WSEL_16: top = 32'h0000_8000;
			default: top = 32'h8000_0000;
		endcase
		c = crc_in & mask;
		if (cfg.reflected) begin
			c = c ^ {24'd0, data_in};
			for (int i = 0; i < 8; i++) begin
				c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
			end
		end else begin
			// align the byte with the top of the register
			unique case (cfg.wsel)
				WSEL_8:  c = c ^ {24'd0, data_in};
				WSEL_16: c = c ^ {16'd0, data_in, 8'd0};
				default: c = c ^ {data_in, 24'd0};
			endcase
			for (int i = 0; i < 8; i++) begin
				c = ((c & top) != 32'd0) ? (((c << 1) ^ poly) & mask) : ((c << 1) & mask);
			end
		end
		crc_out = c & mask;
	end

endmodule

@@ src/ccrc_checker.sv @@
`timescale 1ns / 1ps

module ccrc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_wen,
	input logic [ccrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                    cfg_data,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [31:0]                    crc_value,
	input logic                           status
);
	import ccrc_pkg::*;

	logic [1:0] wsel_q;

	// shadow the width code from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q <= WSEL_32;
		end else if (cfg_wen && (cfg_index == REG_WIDTH_SELECT)) begin
			wsel_q <= cfg_data[1:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_value) && $stable(status))
		else $error("result changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> crc_value == 32'd0)
		else $error("error result carries a nonzero CRC");

	a_invalid_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (wsel_q == WSEL_INVALID) |-> status)
		else $error("invalid width gave an ok status");

	a_width_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (wsel_q == WSEL_8) |-> !status && (crc_value[31:8] == 24'd0))
		else $error("8-bit CRC result not masked");

endmodule

bind configurable_crc_engine ccrc_checker u_ccrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_wen   (cfg_wen),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.crc_value (crc_value),
	.status    (status)
);

@@ tb/configurable_crc_engine_checker.sv @@
`timescale 1ns / 1ps

module configurable_crc_engine_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ccrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           byte_present,
	input  logic                           start_of_message,
	input  logic                           end_of_message,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [31:0]                    crc_value,
	input  logic                           status,
	output int                             mismatches,
	output int                             pending,
	output int                             results_seen
);
	import ccrc_pkg::*;

	typedef struct packed {
		logic [31:0] crc_value;
		logic        status;
	} crc_result_t;

	crc_result_t crc_expected_q[$];
	crc_result_t want;

	// shadow of the engine configuration and running CRC
	logic [1:0]  width_code;
	logic        reflect;
	logic [31:0] poly;
	logic [31:0] init_val;
	logic [31:0] out_mask;
	logic [31:0] crc_state;
	int          n_bad;
	int          n_res;

	function automatic logic [31:0] span_mask(input logic [1:0] w);
		logic [31:0] m;
		case (w)
			WSEL_8:  m = 32'h0000_00FF;
			WSEL_16: m = 32'h0000_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// fold one byte over eight bit steps at the current width and direction
	function automatic logic [31:0] crc_fold(input logic [31:0] crc_in, input logic [7:0] b,
			input logic [1:0] w, input logic refl, input logic [31:0] poly_in);
		logic [31:0] m;
		logic [31:0] p;
		logic [31:0] top;
		logic [31:0] r;
		int          i;
		m = span_mask(w);
		p = poly_in & m;
		r = crc_in & m;
		if (refl) begin
			r = r ^ {24'h0, b};
			for (i = 0; i < 8; i++)
				r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
		end else begin
			case (w)
				WSEL_8: begin
					r = r ^ {24'h0, b};
					top = 32'h0000_0080;
				end
				WSEL_16: begin
					r = r ^ {16'h0, b, 8'h0};
					top = 32'h0000_8000;
				end
				default: begin
					r = r ^ {b, 24'h0};
					top = 32'h8000_0000;
				end
			endcase
			for (i = 0; i < 8; i++)
				r = ((r & top) != 0) ? (((r << 1) ^ p) & m) : ((r << 1) & m);
		end
		return r & m;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code = WSEL_32;
			reflect = 1'b1;
			poly = RESET_POLYNOMIAL;
			init_val = RESET_INITIAL;
			out_mask = RESET_OUTPUT_XOR;
			crc_state = 32'h0;
			crc_expected_q.delete();
			n_bad = 0;
			n_res = 0;
			mismatches <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_res++;
				if (crc_expected_q.size() == 0) begin
					n_bad++;
					$error("result with no item waiting: crc_value %h status %b",
						crc_value, status);
				end else begin
					want = crc_expected_q.pop_front();
					if (crc_value !== want.crc_value) begin
						n_bad++;
						$error("crc_value: expected %h, actual %h", want.crc_value, crc_value);
					end
					if (status !== want.status) begin
						n_bad++;
						$error("status: expected %b, actual %b", want.status, status);
					end
				end
			end

			if (cfg_wen) begin
				case (cfg_index)
					REG_WIDTH_SELECT: width_code = cfg_data[1:0];
					REG_REFLECTED:    reflect = cfg_data[0];
					REG_POLYNOMIAL:   poly = cfg_data;
					REG_INITIAL:      init_val = cfg_data;
					REG_OUTPUT_XOR:   out_mask = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				// invalid width leaves the register alone
				if (width_code != WSEL_INVALID) begin
					if (start_of_message)
						crc_state = init_val & span_mask(width_code);
					if (byte_present)
						crc_state = crc_fold(crc_state, data_byte, width_code, reflect, poly);
				end
				if (end_of_message) begin
					if (width_code != WSEL_INVALID) begin
						want.crc_value = (crc_state ^ out_mask) & span_mask(width_code);
						want.status = 1'b0;
					end else begin
						want.crc_value = 32'h0;
						want.status = 1'b1;
					end
					crc_expected_q.push_back(want);
				end
			end

			mismatches <= n_bad;
			pending <= crc_expected_q.size();
			results_seen <= n_res;
		end
	end

endmodule

@@ tb/configurable_crc_engine_test.sv @@
`timescale 1ns / 1ps

module configurable_crc_engine_test;
	import ccrc_pkg::*;

	typedef struct packed {
		logic [1:0]  width;
		logic        reflect;
		logic [31:0] poly;
		logic [31:0] init_val;
		logic [31:0] out_mask;
	} crc_setting_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic [7:0]           data_byte = '0;
	logic                 byte_present = 1'b0;
	logic                 start_of_message = 1'b0;
	logic                 end_of_message = 1'b0;
	logic                 out_stall = 1'b0;
	wire                  in_stall;
	wire                  out_valid;
	wire [31:0]           crc_value;
	wire                  status;

	int mismatches;
	int pending;
	int results_seen;

	int burst_left = 0;
	bit steady_send = 1'b0;
	int hold_seq = 0;
	int items_sent = 0;
	int settings_used = 0;
	int holds = 0;

	always #10 clk = ~clk;

	configurable_crc_engine u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.byte_present     (byte_present),
		.start_of_message (start_of_message),
		.end_of_message   (end_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.crc_value        (crc_value),
		.status           (status)
	);

	configurable_crc_engine_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.byte_present     (byte_present),
		.start_of_message (start_of_message),
		.end_of_message   (end_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.crc_value        (crc_value),
		.status           (status),
		.mismatches       (mismatches),
		.pending          (pending),
		.results_seen     (results_seen)
	);

	// result side: random stall modes, plus a long hold each time hold_seq moves
	int hold_seen = 0;
	int hold_left = 0;
	int rx_left = 0;
	int rx_mode = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
			rx_left = 0;
		end else begin
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = 120;
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (rx_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= rx_left[2];
				endcase
			end
		end
	end

	function automatic crc_setting_t make_setting(input logic [1:0] w, input logic r,
			input logic [31:0] p, input logic [31:0] i, input logic [31:0] x);
		crc_setting_t s;
		s.width = w;
		s.reflect = r;
		s.poly = p;
		s.init_val = i;
		s.out_mask = x;
		return s;
	endfunction

	function automatic crc_setting_t preset(input int k);
		crc_setting_t s;
		case (k)
			0: s = make_setting(WSEL_32, 1'b1, 32'hEDB8_8320, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			1: s = make_setting(WSEL_32, 1'b0, 32'h04C1_1DB7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			2: s = make_setting(WSEL_32, 1'b1, 32'h82F6_3B78, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			3: s = make_setting(WSEL_16, 1'b0, 32'h0000_1021, 32'h0, 32'h0);
			4: s = make_setting(WSEL_16, 1'b1, 32'h0000_8408, 32'h0, 32'h0);
			5: s = make_setting(WSEL_16, 1'b1, 32'h0000_A001, 32'h0, 32'h0);
			6: s = make_setting(WSEL_8, 1'b0, 32'h0000_009B, 32'h0000_00FF, 32'h0);
			7: s = make_setting(WSEL_8, 1'b1, 32'h0000_00D9, 32'h0, 32'h0);
			8: s = make_setting(WSEL_INVALID, 1'b0, 32'h04C1_1DB7, '1, '1);
			default: s = make_setting(WSEL_8, 1'b1, '1, 32'h0, '1);
		endcase
		return s;
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = 32'h0;
			1: v = '1;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic crc_setting_t random_setting();
		logic [1:0] w;
		w = ($urandom_range(0, 9) == 0) ? WSEL_INVALID : 2'($urandom_range(0, 2));
		return make_setting(w, 1'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word());
	endfunction

	// offer one item; bursts of random length with random gaps in between
	task automatic offer(input logic [7:0] b, input logic pres, input logic sof,
			input logic eof);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_send ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		data_byte <= b;
		byte_present <= pres;
		start_of_message <= sof;
		end_of_message <= eof;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// stop offering and let every result come out
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_engine(input crc_setting_t s);
		cfg_wen <= 1'b1;
		cfg_index <= REG_WIDTH_SELECT;
		cfg_data <= ($urandom() & ~32'h3) | {30'd0, s.width};
		@(posedge clk);
		cfg_index <= REG_REFLECTED;
		cfg_data <= ($urandom() & ~32'h1) | {31'd0, s.reflect};
		@(posedge clk);
		cfg_index <= REG_POLYNOMIAL;
		cfg_data <= s.poly;
		@(posedge clk);
		cfg_index <= REG_INITIAL;
		cfg_data <= s.init_val;
		@(posedge clk);
		cfg_index <= REG_OUTPUT_XOR;
		cfg_data <= s.out_mask;
		@(posedge clk);
		// stray write past the last register must be dropped
		if ($urandom_range(0, 2) == 0) begin
			cfg_index <= CFG_IDX_W'($urandom_range(REG_OUTPUT_XOR + 1, 2 ** CFG_IDX_W - 1));
			cfg_data <= $urandom();
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	task automatic send_message(input int len);
		int k;
		if (len == 0) begin
			offer(8'($urandom()), 1'b0, 1'b1, 1'b1);
		end else begin
			for (k = 0; k < len; k++)
				offer(8'($urandom()), ($urandom_range(0, 9) != 0), (k == 0), (k == len - 1));
		end
	endtask

	initial begin : stimulus
		int           phase;
		int           k;
		int           quota;
		int           first;
		crc_setting_t s;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// CRC-32 out of reset: check string, empty message, byte extremes
		for (k = 0; k < 9; k++)
			offer(8'(32'h31 + k), 1'b1, (k == 0), (k == 8));
		offer(8'h00, 1'b0, 1'b1, 1'b1);
		offer(8'h00, 1'b1, 1'b1, 1'b1);
		offer(8'hFF, 1'b1, 1'b1, 1'b1);
		offer(8'hA5, 1'b1, 1'b0, 1'b1);
		offer(8'h3C, 1'b0, 1'b0, 1'b0);
		offer(8'h7E, 1'b1, 1'b1, 1'b0);
		drain();

		// narrow the width mid-message; polynomial bits above 8 must be ignored
		program_engine(make_setting(WSEL_8, 1'b0, 32'hFFFF_FF9B, 32'h0000_00FF, 32'h0));
		offer(8'h80, 1'b1, 1'b0, 1'b1);
		offer(8'h31, 1'b1, 1'b1, 1'b0);
		offer(8'h32, 1'b1, 1'b0, 1'b1);
		drain();

		program_engine(make_setting(WSEL_INVALID, 1'b1, '1, '1, '1));
		offer(8'h55, 1'b1, 1'b1, 1'b0);
		offer(8'hAA, 1'b1, 1'b0, 1'b1);
		offer(8'h00, 1'b0, 1'b0, 1'b1);
		drain();

		// register must have survived the invalid width untouched
		program_engine(make_setting(WSEL_16, 1'b1, 32'h0000_8408, 32'h0, 32'h0));
		offer(8'h01, 1'b1, 1'b0, 1'b1);
		offer(8'hFF, 1'b1, 1'b1, 1'b1);
		drain();

		phase = 0;
		while (items_sent < 1925) begin
			if (phase < 10)
				s = preset(phase);
			else if ($urandom_range(0, 2) == 0)
				s = preset($urandom_range(0, 9));
			else
				s = random_setting();
			program_engine(s);
			steady_send = ($urandom_range(0, 3) == 0);

			// hold the result side while short messages keep coming
			if (phase % 6 == 2) begin
				hold_seq <= hold_seq + 1;
				holds++;
				for (k = 0; k < 40; k++)
					offer(8'($urandom()), 1'b1, 1'b1, 1'b1);
			end

			quota = $urandom_range(40, 160);
			first = items_sent;
			while (items_sent - first < quota) begin
				if ($urandom_range(0, 5) == 0)
					offer(8'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
				else if ($urandom_range(0, 3) == 0)
					send_message($urandom_range(9, 40));
				else
					send_message($urandom_range(0, 6));
			end
			drain();
			phase++;
		end

		repeat (10) @(posedge clk);
		$display("covered %0d items and %0d results over %0d register settings,",
			items_sent, results_seen, settings_used);
		$display("including %0d long output hold-offs with the input backed up", holds);
		if (mismatches == 0 && pending == 0)
			$display("configurable_crc_engine_test passed");
		else
			$display("configurable_crc_engine_test failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("timed out waiting for the engine");
		$display("configurable_crc_engine_test failed");
		$finish;
	end

endmodule
